FILE: rtl/gnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gnm_pkg;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_PAT_BYTE  = 2'd0,
    CMD_PAT_END   = 2'd1,
    CMD_NAME_BYTE = 2'd2,
    CMD_NAME_END  = 2'd3
  } cmd_e;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNTERM   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Pattern syntax bytes.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Role of one pattern position after parsing.
  typedef enum logic [2:0] {
    K_END,    // at or past the pattern end: a plain receiving position
    K_LIT,    // literal byte
    K_ESC,    // backslash escape, literal is the next byte
    K_ANY,    // question mark
    K_STAR,   // star
    K_CLASS,  // opening bracket of a class
    K_DEAD,   // trailing backslash, never matches
    K_INNER   // inside a token, passes bits along
  } kind_e;

  // Parser state handed from one position to the next.
  typedef enum logic [2:0] {
    PS_NORMAL,
    PS_ESC,
    PS_FIRST,
    PS_BODY,
    PS_SKIP1,
    PS_SKIP2
  } pst_e;

  // Role of a position inside a class.
  typedef enum logic [1:0] {
    EL_NONE,
    EL_SINGLE,
    EL_RANGE
  } elem_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PARSE,
    S_RINIT,
    S_RSWEEP,
    S_ACC,
    S_BINIT,
    S_BSWEEP,
    S_RESULT
  } state_e;

  // Sweep controls broadcast to every cell.
  typedef struct packed {
    logic acc;    // class accumulation sweep
    logic rinit;  // load the rearm start set
    logic binit;  // load the set after a name byte
    logic sweep;  // move completion bits one position right
  } ctl_t;

endpackage
`default_nettype wire

FILE: rtl/glob_name_match_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A pattern byte is written straight into its cell; a pattern end runs the parse wave, then the rearm sweep.
// A name byte runs the class sweep, then the advance sweep; a name item on an open pattern parses first.
// A name end registers its result once the output stage is free, then rearms.
// Every wave crosses all MAX_PATTERN+1 cells, one a cycle; no new item is taken until idle again.
// Reset is asynchronous and active low; it leaves an empty, closed pattern armed at position 0.
module glob_name_match_unit #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0 up: command [1:0], byte_value [9:2], zero fill [15:10].
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0 up: matched [0], supermatch [1], status [3:2], zero fill [7:4].
  output logic [7:0]       m_axis_tdata
);

  // Width that holds a position from 0 to MAX_PATTERN inclusive.
  localparam int unsigned LW   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned NC   = MAX_PATTERN + 1;
  localparam logic [LW-1:0] LAST = LW'(MAX_PATTERN);

  gnm_pkg::state_e state_q, state_d;
  gnm_pkg::cmd_e   cmd_q, cmd_d, in_cmd;
  gnm_pkg::ctl_t   ctl;
  logic [LW-1:0]   cnt_q, cnt_d, len_q, len_d, wr_idx;
  logic [7:0]      name_q, in_byte;
  logic            closed_q, closed_d, ovf_q, ovf_d, open_q, open_d, sm_q, sm_d;
  logic            accept, wr_fire, parse_start, free, load_res, done;
  logic            out_valid_q;
  logic [7:0]      out_data_q;
  logic [1:0]      res_status;
  logic            res_m, res_s;

  logic [7:0]      byte_v [NC];
  logic            pv_v   [NC];
  gnm_pkg::pst_e   pst_v  [NC];
  logic            k_v    [NC];
  logic            ins_v  [NC];
  logic            acc_v  [NC];
  logic [NC-1:0]   open_v, sm_v, end_v;

  assign in_cmd  = gnm_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign in_byte = s_axis_tdata[9:2];
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign done    = cnt_q == LAST;
  assign free    = !out_valid_q || m_axis_tready;

  // Pattern bytes go to the cell at the current length, or to cell 0 when a new pattern opens.
  assign wr_idx  = closed_q ? '0 : len_q;
  assign wr_fire = accept && in_cmd == gnm_pkg::CMD_PAT_BYTE && (wr_idx < LAST);

  // The cell row: each cell holds one pattern position and takes data only from cells up to two away.
  for (genvar g = 0; g < NC; g++) begin : g_cell
    logic [7:0]    nb1, nb2;
    logic          pv_in, k_in, ins_nxt, acc_nxt;
    gnm_pkg::pst_e pst_in;
    if (g + 1 < NC) begin : g_n1
      assign nb1     = byte_v[g+1];
      assign ins_nxt = ins_v[g+1];
      assign acc_nxt = acc_v[g+1];
    end else begin : g_n1_none
      assign nb1     = 8'h00;
      assign ins_nxt = 1'b0;
      assign acc_nxt = 1'b0;
    end
    if (g + 2 < NC) begin : g_n2
      assign nb2 = byte_v[g+2];
    end else begin : g_n2_none
      assign nb2 = 8'h00;
    end
    if (g == 0) begin : g_head
      assign pv_in  = parse_start;
      assign pst_in = gnm_pkg::PS_NORMAL;
      assign k_in   = 1'b0;
    end else begin : g_body
      assign pv_in  = pv_v[g-1];
      assign pst_in = pst_v[g-1];
      assign k_in   = k_v[g-1];
    end
    gnm_cell #(.IDX(g), .LW(LW)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .len_i        (len_q),
      .wr_en_i      (wr_fire && wr_idx == LW'(g)),
      .wr_byte_i    (in_byte),
      .name_i       (name_q),
      .nb1_i        (nb1),
      .nb2_i        (nb2),
      .pv_i         (pv_in),
      .pst_i        (pst_in),
      .k_i          (k_in),
      .inside_nxt_i (ins_nxt),
      .acc_nxt_i    (acc_nxt),
      .byte_o       (byte_v[g]),
      .pv_o         (pv_v[g]),
      .pst_o        (pst_v[g]),
      .k_o          (k_v[g]),
      .inside_o     (ins_v[g]),
      .acc_o        (acc_v[g]),
      .open_o       (open_v[g]),
      .sm_o         (sm_v[g]),
      .end_o        (end_v[g])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gnm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            gnm_pkg::CMD_PAT_BYTE:  state_d = gnm_pkg::S_IDLE;
            gnm_pkg::CMD_PAT_END:   state_d = gnm_pkg::S_PARSE;
            gnm_pkg::CMD_NAME_BYTE: state_d = closed_q ? gnm_pkg::S_ACC : gnm_pkg::S_PARSE;
            gnm_pkg::CMD_NAME_END:  state_d = closed_q ? gnm_pkg::S_RESULT : gnm_pkg::S_PARSE;
            default:                state_d = gnm_pkg::S_IDLE;
          endcase
        end
      end
      gnm_pkg::S_PARSE:  if (done) state_d = gnm_pkg::S_RINIT;
      gnm_pkg::S_RINIT:  state_d = gnm_pkg::S_RSWEEP;
      gnm_pkg::S_RSWEEP: begin
        if (done) begin
          if (cmd_q == gnm_pkg::CMD_NAME_BYTE) begin
            state_d = gnm_pkg::S_ACC;
          end else if (cmd_q == gnm_pkg::CMD_NAME_END) begin
            state_d = gnm_pkg::S_RESULT;
          end else begin
            state_d = gnm_pkg::S_IDLE;
          end
        end
      end
      gnm_pkg::S_ACC:    if (done) state_d = gnm_pkg::S_BINIT;
      gnm_pkg::S_BINIT:  state_d = gnm_pkg::S_BSWEEP;
      gnm_pkg::S_BSWEEP: if (done) state_d = gnm_pkg::S_IDLE;
      gnm_pkg::S_RESULT: if (free) state_d = gnm_pkg::S_RINIT;
      default:           state_d = gnm_pkg::S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = state_q == gnm_pkg::S_IDLE;
    parse_start   = state_q == gnm_pkg::S_PARSE && cnt_q == '0;
    ctl.acc       = state_q == gnm_pkg::S_ACC;
    ctl.rinit     = state_q == gnm_pkg::S_RINIT;
    ctl.binit     = state_q == gnm_pkg::S_BINIT;
    ctl.sweep     = state_q == gnm_pkg::S_RSWEEP || state_q == gnm_pkg::S_BSWEEP;
    load_res      = state_q == gnm_pkg::S_RESULT && free;
  end

  // Result: a bad pattern status forces both flags low.
  always_comb begin
    if (ovf_q) begin
      res_status = gnm_pkg::ST_TOO_LONG;
    end else if (open_q) begin
      res_status = gnm_pkg::ST_UNTERM;
    end else begin
      res_status = gnm_pkg::ST_OK;
    end
    res_s = sm_q && res_status == gnm_pkg::ST_OK;
    res_m = ((|end_v) || sm_q) && res_status == gnm_pkg::ST_OK;
  end

  // Bookkeeping registers.
  always_comb begin
    cmd_d    = cmd_q;
    closed_d = closed_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    open_d   = open_q;
    sm_d     = sm_q;
    if (state_d != state_q) begin
      cnt_d = '0;
    end else begin
      cnt_d = done ? cnt_q : cnt_q + 1'b1;
    end
    if (accept) begin
      cmd_d = in_cmd;
      if (in_cmd == gnm_pkg::CMD_PAT_BYTE) begin
        closed_d = 1'b0;
        if (wr_idx < LAST) begin
          len_d = wr_idx + 1'b1;
          ovf_d = closed_q ? 1'b0 : ovf_q;
        end else begin
          len_d = wr_idx;
          ovf_d = 1'b1;
        end
      end else begin
        closed_d = 1'b1;
      end
    end
    if (state_q == gnm_pkg::S_PARSE) begin
      open_d = (parse_start ? 1'b0 : open_q) | (|open_v);
    end
    if (ctl.rinit) begin
      sm_d = 1'b0;
    end else if (ctl.binit) begin
      sm_d = sm_q | (|sm_v);
    end
    if (load_res) begin
      // Marks the pending rearm as the last step of this name end.
      cmd_d = gnm_pkg::CMD_PAT_END;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gnm_pkg::S_IDLE;
      cmd_q       <= gnm_pkg::CMD_PAT_END;
      cnt_q       <= '0;
      len_q       <= '0;
      closed_q    <= 1'b1;
      ovf_q       <= 1'b0;
      open_q      <= 1'b0;
      sm_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      closed_q <= closed_d;
      ovf_q    <= ovf_d;
      open_q   <= open_d;
      sm_q     <= sm_d;
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_cmd == gnm_pkg::CMD_NAME_BYTE) begin
      name_q <= in_byte;
    end
    if (load_res) begin
      out_data_q <= {4'b0000, res_status, res_s, res_m};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A result with a bad status never claims a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3:2] != gnm_pkg::ST_OK) |-> (m_axis_tdata[1:0] == 2'b00))
    else $error("bad status result carries match flags");

  // The stored length never runs past the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LAST)
    else $error("pattern length beyond store");

  // A pattern end always starts a parse wave with the pattern closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_cmd == gnm_pkg::CMD_PAT_END) |=> (state_q == gnm_pkg::S_PARSE && closed_q))
    else $error("pattern end did not start parsing");

  // A result is only loaded while the output stage can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(out_valid_q) && !$past(m_axis_tready)) |-> $stable(out_data_q))
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

FILE: rtl/gnm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module gnm_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned LW  = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gnm_pkg::ctl_t ctl_i,
  input  wire logic [LW-1:0] len_i,
  input  wire logic          wr_en_i,
  input  wire logic [7:0]    wr_byte_i,
  input  wire logic [7:0]    name_i,
  input  wire logic [7:0]    nb1_i,
  input  wire logic [7:0]    nb2_i,
  input  wire logic          pv_i,
  input  wire gnm_pkg::pst_e pst_i,
  input  wire logic          k_i,
  input  wire logic          inside_nxt_i,
  input  wire logic          acc_nxt_i,
  output logic [7:0]         byte_o,
  output logic               pv_o,
  output gnm_pkg::pst_e      pst_o,
  output logic               k_o,
  output logic               inside_o,
  output logic               acc_o,
  output logic               open_o,
  output logic               sm_o,
  output logic               end_o
);

  logic [7:0]     byte_q;
  gnm_pkg::kind_e kind_q, kind_d;
  gnm_pkg::elem_e elem_q, elem_d;
  gnm_pkg::pst_e  pst_q, pst_d;
  logic           inv_q, inv_d, dstar_q, dstar_d, inside_q, inside_d;
  logic           pv_q, k_q, k_d, act_q, act_d, acc_q, acc_d;
  logic           in_pat, p1, p2, at_len, start, is_star, takes, hit;

  assign in_pat = IDX < int'(len_i);
  assign p1     = (IDX + 1) < int'(len_i);
  assign p2     = (IDX + 2) < int'(len_i);
  assign at_len = IDX == int'(len_i);

  // Parse step: decides this position's role from the state handed in.
  always_comb begin
    kind_d   = gnm_pkg::K_END;
    elem_d   = gnm_pkg::EL_NONE;
    pst_d    = gnm_pkg::PS_NORMAL;
    inv_d    = 1'b0;
    dstar_d  = 1'b0;
    inside_d = 1'b0;
    if (in_pat) begin
      unique case (pst_i)
        gnm_pkg::PS_NORMAL: begin
          if (byte_q == gnm_pkg::CH_BSLASH) begin
            kind_d = p1 ? gnm_pkg::K_ESC : gnm_pkg::K_DEAD;
            pst_d  = p1 ? gnm_pkg::PS_ESC : gnm_pkg::PS_NORMAL;
          end else if (byte_q == gnm_pkg::CH_QUEST) begin
            kind_d = gnm_pkg::K_ANY;
          end else if (byte_q == gnm_pkg::CH_STAR) begin
            kind_d  = gnm_pkg::K_STAR;
            dstar_d = p1 && (nb1_i == gnm_pkg::CH_STAR);
          end else if (byte_q == gnm_pkg::CH_LBRACK) begin
            kind_d = gnm_pkg::K_CLASS;
            inv_d  = p1 && (nb1_i == gnm_pkg::CH_BANG);
            pst_d  = gnm_pkg::PS_FIRST;
          end else begin
            kind_d = gnm_pkg::K_LIT;
          end
        end
        gnm_pkg::PS_ESC: begin
          kind_d = gnm_pkg::K_INNER;
        end
        gnm_pkg::PS_FIRST, gnm_pkg::PS_BODY: begin
          kind_d = gnm_pkg::K_INNER;
          if (pst_i == gnm_pkg::PS_FIRST && byte_q == gnm_pkg::CH_BANG) begin
            inside_d = 1'b1;
            pst_d    = gnm_pkg::PS_BODY;
          end else if (byte_q == gnm_pkg::CH_RBRACK) begin
            pst_d = gnm_pkg::PS_NORMAL;
          end else begin
            inside_d = 1'b1;
            if (p2 && nb1_i == gnm_pkg::CH_DASH && nb2_i != gnm_pkg::CH_RBRACK) begin
              elem_d = gnm_pkg::EL_RANGE;
              pst_d  = gnm_pkg::PS_SKIP1;
            end else begin
              elem_d = gnm_pkg::EL_SINGLE;
              pst_d  = gnm_pkg::PS_BODY;
            end
          end
        end
        gnm_pkg::PS_SKIP1: begin
          kind_d   = gnm_pkg::K_INNER;
          inside_d = 1'b1;
          pst_d    = gnm_pkg::PS_SKIP2;
        end
        gnm_pkg::PS_SKIP2: begin
          kind_d   = gnm_pkg::K_INNER;
          inside_d = 1'b1;
          pst_d    = gnm_pkg::PS_BODY;
        end
        default: begin
          kind_d = gnm_pkg::K_END;
        end
      endcase
    end
  end

  assign start   = kind_q != gnm_pkg::K_INNER;
  assign is_star = kind_q == gnm_pkg::K_STAR;

  always_comb begin
    unique case (elem_q)
      gnm_pkg::EL_SINGLE: hit = name_i == byte_q;
      gnm_pkg::EL_RANGE:  hit = (name_i >= byte_q) && (name_i <= nb2_i);
      default:            hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (kind_q)
      gnm_pkg::K_ANY:   takes = 1'b1;
      gnm_pkg::K_LIT:   takes = name_i == byte_q;
      gnm_pkg::K_ESC:   takes = name_i == nb1_i;
      gnm_pkg::K_CLASS: takes = acc_q ^ inv_q;
      default:          takes = 1'b0;
    endcase
  end

  assign acc_d = hit | (inside_nxt_i & acc_nxt_i);

  always_comb begin
    act_d = act_q;
    k_d   = k_q;
    if (ctl_i.rinit) begin
      act_d = IDX == 0;
      k_d   = (IDX == 0) && is_star;
    end else if (ctl_i.binit) begin
      act_d = act_q & is_star;
      k_d   = act_q & (is_star | (start & takes));
    end else if (ctl_i.sweep) begin
      act_d = act_q | (start & k_i);
      k_d   = start ? (is_star & k_i) : k_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      byte_q <= wr_byte_i;
    end
    if (ctl_i.acc) begin
      acc_q <= acc_d;
    end
    k_q <= k_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= gnm_pkg::K_END;
      elem_q   <= gnm_pkg::EL_NONE;
      pst_q    <= gnm_pkg::PS_NORMAL;
      inv_q    <= 1'b0;
      dstar_q  <= 1'b0;
      inside_q <= 1'b0;
      pv_q     <= 1'b0;
      act_q    <= IDX == 0;
    end else begin
      pv_q  <= pv_i;
      act_q <= act_d;
      if (pv_i) begin
        kind_q   <= kind_d;
        elem_q   <= elem_d;
        pst_q    <= pst_d;
        inv_q    <= inv_d;
        dstar_q  <= dstar_d;
        inside_q <= inside_d;
      end
    end
  end

  assign byte_o   = byte_q;
  assign pv_o     = pv_q;
  assign pst_o    = pst_q;
  assign k_o      = k_q;
  assign inside_o = inside_q;
  assign acc_o    = acc_q;
  assign open_o   = pv_i && at_len &&
                    (pst_i == gnm_pkg::PS_FIRST || pst_i == gnm_pkg::PS_BODY);
  assign sm_o     = act_q & is_star & dstar_q;
  assign end_o    = act_q & at_len;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int PAT_MAX = 64;

  typedef struct packed {
    logic [1:0] status;
    logic       supermatch;
    logic       matched;
  } verdict_t;

  // Kinds of token that a pattern position can start.
  typedef enum int {TK_LIT, TK_ANY, TK_STAR, TK_CLASS, TK_DEAD, TK_OPEN} tok_e;

  // Scoreboard: keeps its own copy of the matcher state and the verdicts still owed.
  class glob_scoreboard;
    logic [7:0] pat[PAT_MAX];
    int unsigned plen;
    bit live[PAT_MAX+1];
    bit super_seen;
    bit overflow;
    bit closed;
    verdict_t owed[$];
    int errors;

    function new();
      plen = 0;
      overflow = 0;
      closed = 1;
      errors = 0;
      rearm();
    endfunction

    // Walks the class starting at p; returns the index of its closing bracket or plen.
    function int unsigned class_walk(int unsigned p, logic [7:0] b, output bit hit);
      int unsigned q;
      bit inv;
      bit m;
      q = p + 1;
      inv = 0;
      m = 0;
      if (q < plen && pat[q] == gnm_pkg::CH_BANG) begin
        inv = 1;
        q++;
      end
      while (q < plen && pat[q] != gnm_pkg::CH_RBRACK) begin
        if (q + 2 < plen && pat[q+1] == gnm_pkg::CH_DASH &&
            pat[q+2] != gnm_pkg::CH_RBRACK) begin
          if (b >= pat[q] && b <= pat[q+2]) m = 1;
          q += 3;
        end else begin
          if (b == pat[q]) m = 1;
          q++;
        end
      end
      hit = (m != inv);
      return q;
    endfunction

    function tok_e token_at(int unsigned p, output int unsigned nxt);
      bit h;
      int unsigned q;
      logic [7:0] c;
      c = pat[p];
      if (c == gnm_pkg::CH_BSLASH) begin
        if (p + 1 < plen) begin
          nxt = p + 2;
          return TK_LIT;
        end
        nxt = plen;
        return TK_DEAD;
      end
      if (c == gnm_pkg::CH_QUEST) begin
        nxt = p + 1;
        return TK_ANY;
      end
      if (c == gnm_pkg::CH_STAR) begin
        nxt = p + 1;
        return TK_STAR;
      end
      if (c == gnm_pkg::CH_LBRACK) begin
        q = class_walk(p, 8'h00, h);
        if (q >= plen) begin
          nxt = plen;
          return TK_OPEN;
        end
        nxt = q + 1;
        return TK_CLASS;
      end
      nxt = p + 1;
      return TK_LIT;
    endfunction

    function bit token_accepts(int unsigned p, tok_e k, logic [7:0] b);
      bit h;
      int unsigned q;
      case (k)
        TK_ANY: return 1;
        TK_LIT: begin
          if (pat[p] == gnm_pkg::CH_BSLASH) return pat[p+1] == b;
          return pat[p] == b;
        end
        TK_CLASS: begin
          q = class_walk(p, b, h);
          return h;
        end
        default: return 0;
      endcase
    endfunction

    // Positions reachable through stars become live too.
    function void star_closure();
      int unsigned n;
      for (int unsigned p = 0; p < plen; p++)
        if (live[p] && token_at(p, n) == TK_STAR) live[n] = 1;
    endfunction

    function void rearm();
      foreach (live[i]) live[i] = 0;
      live[0] = 1;
      super_seen = 0;
      star_closure();
    endfunction

    function logic [1:0] pattern_health();
      int unsigned p;
      int unsigned n;
      p = 0;
      if (overflow) return gnm_pkg::ST_TOO_LONG;
      while (p < plen) begin
        if (token_at(p, n) == TK_OPEN) return gnm_pkg::ST_UNTERM;
        p = n;
      end
      return gnm_pkg::ST_OK;
    endfunction

    // Notes one accepted input item.
    function void note_item(gnm_pkg::cmd_e cmd, logic [7:0] b);
      bit nxt_live[PAT_MAX+1];
      int unsigned n;
      tok_e k;
      verdict_t v;
      if (cmd == gnm_pkg::CMD_PAT_BYTE) begin
        if (closed) begin
          closed = 0;
          plen = 0;
          overflow = 0;
        end
        if (plen < PAT_MAX) begin
          pat[plen] = b;
          plen++;
        end else begin
          overflow = 1;
        end
        return;
      end
      if (cmd == gnm_pkg::CMD_PAT_END) begin
        closed = 1;
        rearm();
        return;
      end
      if (!closed) begin
        closed = 1;
        rearm();
      end
      if (cmd == gnm_pkg::CMD_NAME_BYTE) begin
        foreach (nxt_live[i]) nxt_live[i] = 0;
        for (int unsigned p = 0; p < plen; p++) begin
          if (live[p]) begin
            k = token_at(p, n);
            if (k == TK_STAR) begin
              if (p + 1 < plen && pat[p+1] == gnm_pkg::CH_STAR) super_seen = 1;
              nxt_live[p] = 1;
            end else if (token_accepts(p, k, b)) begin
              nxt_live[n] = 1;
            end
          end
        end
        live = nxt_live;
        star_closure();
        return;
      end
      v.status = pattern_health();
      v.supermatch = super_seen;
      v.matched = live[plen] || super_seen;
      if (v.status != gnm_pkg::ST_OK) begin
        v.matched = 0;
        v.supermatch = 0;
      end
      owed.push_back(v);
      rearm();
    endfunction

    // Checks one accepted result against the oldest verdict owed.
    function void check_verdict(logic [7:0] data);
      verdict_t want;
      verdict_t got;
      got = data[3:0];
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", data);
        return;
      end
      want = owed.pop_front();
      if (got !== want || data[7:4] !== 4'h0) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected m=%b s=%b st=%0d, got m=%b s=%b st=%0d fill=%h",
                   want.matched, want.supermatch, want.status,
                   got.matched, got.supermatch, got.status, data[7:4]);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [7:0]  m_axis_tdata;

  glob_scoreboard board = new();
  bit quiet_tail = 0;
  bit hold_off = 0;

  always #4 clk_i = ~clk_i;

  glob_name_match_unit #(.MAX_PATTERN(PAT_MAX)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Offers one item and holds it until the block takes it.
  task automatic send_item(gnm_pkg::cmd_e cmd, logic [7:0] b);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {6'b0, b, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(cmd, b);
    @(negedge clk_i);
  endtask

  task automatic send_text(gnm_pkg::cmd_e cmd, string s);
    for (int i = 0; i < s.len(); i++) send_item(cmd, s[i]);
  endtask

  task automatic try_name(string pattern, string name);
    send_text(gnm_pkg::CMD_PAT_BYTE, pattern);
    send_item(gnm_pkg::CMD_PAT_END, 8'h00);
    send_text(gnm_pkg::CMD_NAME_BYTE, name);
    send_item(gnm_pkg::CMD_NAME_END, 8'h00);
  endtask

  function automatic logic [7:0] pick_byte(bit glob_rich);
    logic [7:0] alpha[10] = '{"a", "b", "c", "/", gnm_pkg::CH_STAR, gnm_pkg::CH_QUEST,
                              gnm_pkg::CH_LBRACK, gnm_pkg::CH_RBRACK, gnm_pkg::CH_BANG,
                              gnm_pkg::CH_DASH};
    if (glob_rich && $urandom_range(0, 3) != 0) return alpha[$urandom_range(0, 9)];
    if ($urandom_range(0, 9) == 0) return gnm_pkg::CH_BSLASH;
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'("a" + $urandom_range(0, 3));
  endfunction

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering items.
  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) m_axis_tready <= 0;
      else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else m_axis_tready <= 1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata);

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int sent;
    int plen;
    int nlen;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed part.
    send_item(gnm_pkg::CMD_NAME_END, 8'h00);
    try_name("a*b", "axxb");
    try_name("**", "x");
    try_name("[!a-c]?", {8'hFF, 8'h00});
    try_name("[]", "]");
    try_name("[!]", "q");
    try_name("[ab", "a");
    try_name("a\\", "a");
    try_name("\\*", "*");
    send_item(gnm_pkg::CMD_NAME_END, 8'h00);
    send_item(gnm_pkg::CMD_PAT_END, 8'h00);
    send_item(gnm_pkg::CMD_PAT_BYTE, "z");
    send_item(gnm_pkg::CMD_NAME_BYTE, "z");
    send_item(gnm_pkg::CMD_NAME_END, 8'h00);
    for (int i = 0; i < PAT_MAX + 2; i++) send_item(gnm_pkg::CMD_PAT_BYTE, "*");
    send_item(gnm_pkg::CMD_NAME_END, 8'h00);

    // Long hold-off while names keep arriving, to fill the block.
    hold_off = 1;
    fork
      begin
        repeat (6) begin
          send_item(gnm_pkg::CMD_NAME_BYTE, "q");
          send_item(gnm_pkg::CMD_NAME_END, 8'h00);
        end
      end
      begin
        repeat (3000) @(negedge clk_i);
        hold_off = 0;
      end
    join

    // Random part: mostly well-formed pattern then names, some loose noise.
    sent = 0;
    while (sent < 1600) begin
      if (sent > 1300) quiet_tail = 1;
      if ($urandom_range(0, 9) == 0) begin
        send_item(gnm_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom));
        sent++;
      end else begin
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
        for (int i = 0; i < plen; i++) send_item(gnm_pkg::CMD_PAT_BYTE, pick_byte(1));
        if ($urandom_range(0, 3) != 0) send_item(gnm_pkg::CMD_PAT_END, 8'h00);
        sent += plen + 1;
        repeat ($urandom_range(1, 3)) begin
          nlen = $urandom_range(0, 8);
          for (int i = 0; i < nlen; i++) send_item(gnm_pkg::CMD_NAME_BYTE, pick_byte(0));
          send_item(gnm_pkg::CMD_NAME_END, 8'h00);
          sent += nlen + 1;
        end
      end
    end
    s_axis_tvalid <= 0;

    fork
      wait (board.owed.size() == 0);
      begin
        repeat (200000) @(posedge clk_i);
        board.errors++;
      end
    join_any
    disable fork;
    repeat (4 * PAT_MAX + 20) @(posedge clk_i);
    if (board.errors == 0 && board.owed.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/gnm_pkg.sv
rtl/gnm_cell.sv
rtl/glob_name_match_unit.sv
tb/tb.sv
